[design/sbct_pkg.sv]
// ----------------------------------------------------------------------------
// sbct_pkg
// shared types, codes and helpers for the swept box collision test
// ----------------------------------------------------------------------------
`default_nettype none

package sbct_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int SIZE_BITS      = 16;
  localparam int EPS_BITS       = 8;
  localparam int CAP_BITS       = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int AXIS_BITS      = 2;

  localparam logic [EPS_BITS-1:0] EPS_RESET = 8'd3;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 16'd512;

  localparam logic [CFG_IDX_BITS-1:0] REG_EPSILON    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MARGIN_CAP = 2'd1;

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_TEST = 1'b1;

  localparam logic [AXIS_BITS-1:0] HIT_NONE = 2'd0;
  localparam logic [AXIS_BITS-1:0] AXIS_DONE = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CAPTURE,
    OP_START,
    OP_PREP,
    OP_STEP,
    OP_EVAL,
    OP_MUL,
    OP_ADD,
    OP_HIT,
    OP_REPORT
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [AXIS_BITS-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic vel_zero;
    logic div_last;
    logic q_ge_budget;
    logic margin_ok;
    logic overlap_ok;
    logic out_free;
  } status_t;

  // test order y, x, z
  function automatic logic [AXIS_BITS-1:0] axis_of(input logic [AXIS_BITS-1:0] k);
    logic [AXIS_BITS-1:0] a;
    case (k)
      2'd0:    a = 2'd1;
      2'd1:    a = 2'd0;
      default: a = 2'd2;
    endcase
    return a;
  endfunction

  // the two axes other than a
  function automatic logic [AXIS_BITS-1:0] other_of(input logic [AXIS_BITS-1:0] a,
                                                    input logic j);
    logic [AXIS_BITS-1:0] b;
    case (a)
      2'd0:    b = j ? 2'd2 : 2'd1;
      2'd1:    b = j ? 2'd2 : 2'd0;
      default: b = j ? 2'd1 : 2'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[design/sbct_ctrl.sv]
// ----------------------------------------------------------------------------
// sbct_ctrl
// sequencer stepping through axes, division, shift and overlap checks
// ----------------------------------------------------------------------------
`default_nettype none

module sbct_ctrl
  import sbct_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_opcode,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SEL  = 9'b000000010,
    S_PREP = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_EVAL = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_ADD  = 9'b001000000,
    S_CHK  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [AXIS_BITS-1:0] k_r, k_nxt;
  logic                 j_r, j_nxt;
  logic [AXIS_BITS-1:0] ax, ob;

  assign ax = axis_of(k_r);
  assign ob = other_of(ax, j_r);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.idx   = ax;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OPC_LOAD) begin
            cmd.op = OP_LOAD;
          end else begin
            cmd.op    = OP_CAPTURE;
            k_nxt     = '0;
            state_nxt = S_SEL;
          end
        end
      end
      S_SEL: begin
        if (k_r == AXIS_DONE) begin
          state_nxt = S_OUT;
        end else if (st.vel_zero) begin
          k_nxt = k_r + 2'd1;
        end else begin
          cmd.op    = OP_START;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op    = OP_PREP;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_STEP;
        if (st.div_last) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.op = OP_EVAL;
        if (st.q_ge_budget) begin
          state_nxt = S_OUT;
        end else if (!st.margin_ok) begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_SEL;
        end else begin
          j_nxt     = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        cmd.idx   = ob;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.op    = OP_ADD;
        cmd.idx   = ob;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.idx = ob;
        if (!st.overlap_ok) begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_SEL;
        end else if (j_r) begin
          cmd.op    = OP_HIT;
          state_nxt = S_OUT;
        end else begin
          j_nxt     = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.op    = OP_REPORT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      j_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

`default_nettype wire

[design/sbct_dp.sv]
// ----------------------------------------------------------------------------
// sbct_dp
// box storage, serial divider, shared multiplier and compare logic
// ----------------------------------------------------------------------------
`default_nettype none

module sbct_dp
  import sbct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire cmd_t                            cmd,
  output status_t                              st,
  input  wire logic                            cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]         cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]        cfg_data,
  input  wire logic signed [COORD_BITS-1:0]    box_x,
  input  wire logic signed [COORD_BITS-1:0]    box_y,
  input  wire logic signed [COORD_BITS-1:0]    box_z,
  input  wire logic [SIZE_BITS-1:0]            box_width,
  input  wire logic [SIZE_BITS-1:0]            box_height,
  input  wire logic [SIZE_BITS-1:0]            box_depth,
  input  wire logic signed [COORD_BITS-1:0]    vel_x,
  input  wire logic signed [COORD_BITS-1:0]    vel_y,
  input  wire logic signed [COORD_BITS-1:0]    vel_z,
  input  wire logic [COORD_BITS-2:0]           time_budget,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [AXIS_BITS-1:0]                 out_hit_axis,
  output logic signed [COORD_BITS-1:0]         out_hit_time,
  output logic                                 out_time_saturated
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 3;
  localparam int NW = DW + FRAC_BITS;
  localparam int GW = CB + 3;
  localparam int PW = 2 * CB - 1;
  localparam int EW = 2 * CB + 2;
  localparam int CW = $clog2(NW);
  localparam logic [NW-1:0] TMAX_U = NW'({(CB-1){1'b1}});
  localparam logic [NW-1:0] TMIN_U = TMAX_U + NW'(1);
  localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

  logic signed [CB-1:0]        mpos_r [3];
  logic [SIZE_BITS-1:0]        msize_r [3];
  logic signed [CB-1:0]        mvel_r [3];
  logic [CB-2:0]               budget_r;
  logic signed [CB-1:0]        spos_r [3];
  logic [SIZE_BITS-1:0]        ssize_r [3];
  logic [EPS_BITS-1:0]         eps_r;
  logic [CAP_BITS-1:0]         cap_r;

  logic [AXIS_BITS-1:0]        ax_r;
  logic signed [CB-1:0]        v_r, s_r, m_r;
  logic [SIZE_BITS-1:0]        ss_r, ms_r;

  logic [CB-1:0]               rem_r;
  logic [NW-1:0]               quo_r;
  logic [CB-1:0]               den_r;
  logic [CW-1:0]               dcnt_r;
  logic                        neg_r;

  logic signed [CB-1:0]        time_r;
  logic                        sat_r;
  logic [AXIS_BITS-1:0]        axis_r;
  logic [CB-2:0]               dt_r;
  logic [PW-1:0]               prod_r;
  logic                        pneg_r;
  logic signed [EW-1:0]        mb_r;

  logic                        out_valid_r;
  logic [AXIS_BITS-1:0]        out_axis_r;
  logic signed [CB-1:0]        out_time_r;
  logic                        out_sat_r;

  // ---- selected entries
  logic signed [CB-1:0]        sel_mpos, sel_mvel, sel_spos;
  logic [SIZE_BITS-1:0]        sel_msize, sel_ssize;
  logic [CB-1:0]               sel_absv;

  always_comb begin
    sel_mpos  = mpos_r[0];
    sel_mvel  = mvel_r[0];
    sel_spos  = spos_r[0];
    sel_msize = msize_r[0];
    sel_ssize = ssize_r[0];
    case (cmd.idx)
      2'd1: begin
        sel_mpos  = mpos_r[1];
        sel_mvel  = mvel_r[1];
        sel_spos  = spos_r[1];
        sel_msize = msize_r[1];
        sel_ssize = ssize_r[1];
      end
      2'd2: begin
        sel_mpos  = mpos_r[2];
        sel_mvel  = mvel_r[2];
        sel_spos  = spos_r[2];
        sel_msize = msize_r[2];
        sel_ssize = ssize_r[2];
      end
      default: begin
      end
    endcase
    sel_absv = sel_mvel[CB-1] ? CB'(-sel_mvel) : CB'(sel_mvel);
  end

  // ---- gap along the tested axis
  logic signed [DW-1:0] s_e, m_e, s_hi, m_hi, hi, lo, span;
  logic [DW-1:0]        abs_dist;
  logic [CB-1:0]        abs_v;

  always_comb begin
    s_e      = DW'(s_r);
    m_e      = DW'(m_r);
    s_hi     = s_e + signed'(DW'(ss_r));
    m_hi     = m_e + signed'(DW'(ms_r));
    hi       = (s_hi > m_hi) ? s_hi : m_hi;
    lo       = (s_e < m_e) ? s_e : m_e;
    span     = hi - lo - signed'(DW'(ss_r)) - signed'(DW'(ms_r));
    abs_dist = span[DW-1] ? DW'(-span) : DW'(span);
    abs_v    = v_r[CB-1] ? CB'(-v_r) : CB'(v_r);
  end

  // ---- divider step
  logic [CB:0]   trial;
  logic          qbit;
  logic [CB-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? CB'(trial - {1'b0, den_r}) : CB'(trial);
  end

  // ---- quotient clipping and margin
  logic                 pos_sat, neg_sat;
  logic signed [CB-1:0] q;
  logic signed [GW-1:0] gap, g2;

  always_comb begin
    pos_sat = !neg_r && (quo_r > TMAX_U);
    neg_sat = neg_r && (quo_r > TMIN_U);
    if (pos_sat) begin
      q = signed'(CB'(TMAX_U));
    end else if (neg_sat) begin
      q = signed'(CB'(TMIN_U));
    end else if (neg_r) begin
      q = signed'(CB'(-quo_r[CB-1:0]));
    end else begin
      q = signed'(quo_r[CB-1:0]);
    end
    if (!v_r[CB-1]) begin
      gap = GW'(s_r) - GW'(m_r) - signed'(GW'(ms_r));
    end else begin
      gap = GW'(m_r) - GW'(s_r) - signed'(GW'(ss_r));
    end
    g2 = gap <<< 1;
    st.q_ge_budget = (q >= signed'(CB'(budget_r)));
    st.margin_ok   = (g2 > -signed'(GW'(ss_r))) && (gap > -signed'(GW'(cap_r)));
  end

  // ---- shifted offset and overlap
  logic [PW-FRAC_BITS-1:0] dmag;
  logic signed [EW-1:0]    dsh;
  logic signed [EW-1:0]    mb_hi, sb_lo, sb_hi, ohi, olo, rhs;

  always_comb begin
    dmag  = prod_r[PW-1:FRAC_BITS];
    dsh   = pneg_r ? -signed'(EW'(dmag)) : signed'(EW'(dmag));
    mb_hi = mb_r + signed'(EW'(sel_msize));
    sb_lo = EW'(sel_spos);
    sb_hi = sb_lo + signed'(EW'(sel_ssize));
    ohi   = (mb_hi > sb_hi) ? mb_hi : sb_hi;
    olo   = (mb_r < sb_lo) ? mb_r : sb_lo;
    rhs   = signed'(EW'(sel_msize)) + signed'(EW'(sel_ssize)) - signed'(EW'(eps_r));
    st.overlap_ok = ((ohi - olo) < rhs);
  end

  always_comb begin
    st.vel_zero = (sel_mvel == '0);
    st.div_last = (dcnt_r == LAST_STEP);
    st.out_free = !out_valid_r || out_ready;
  end

  // ---- config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_EPSILON) begin
        eps_r <= cfg_data[EPS_BITS-1:0];
      end else if (cfg_index == REG_MARGIN_CAP) begin
        cap_r <= cfg_data[CAP_BITS-1:0];
      end
    end
  end

  // ---- moving box state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        mpos_r[i]  <= '0;
        msize_r[i] <= '0;
        mvel_r[i]  <= '0;
      end
      budget_r <= '0;
    end else if (cmd.op == OP_LOAD) begin
      mpos_r[0]  <= box_x;
      mpos_r[1]  <= box_y;
      mpos_r[2]  <= box_z;
      msize_r[0] <= box_width;
      msize_r[1] <= box_height;
      msize_r[2] <= box_depth;
      mvel_r[0]  <= vel_x;
      mvel_r[1]  <= vel_y;
      mvel_r[2]  <= vel_z;
      budget_r   <= time_budget;
    end
  end

  // ---- working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        spos_r[0]  <= box_x;
        spos_r[1]  <= box_y;
        spos_r[2]  <= box_z;
        ssize_r[0] <= box_width;
        ssize_r[1] <= box_height;
        ssize_r[2] <= box_depth;
        time_r     <= signed'(CB'(budget_r));
        sat_r      <= 1'b0;
        axis_r     <= HIT_NONE;
      end
      OP_START: begin
        ax_r <= cmd.idx;
        v_r  <= sel_mvel;
        s_r  <= sel_spos;
        m_r  <= sel_mpos;
        ss_r <= sel_ssize;
        ms_r <= sel_msize;
      end
      OP_PREP: begin
        quo_r  <= {abs_dist, {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        den_r  <= abs_v;
        neg_r  <= span[DW-1];
        dcnt_r <= '0;
      end
      OP_STEP: begin
        quo_r  <= {quo_r[NW-2:0], qbit};
        rem_r  <= rem_nxt;
        dcnt_r <= dcnt_r + CW'(1);
      end
      OP_EVAL: begin
        time_r <= q;
        sat_r  <= pos_sat || neg_sat;
        dt_r   <= q[CB-1] ? '0 : q[CB-2:0];
      end
      OP_MUL: begin
        prod_r <= PW'(sel_absv * dt_r);
        pneg_r <= sel_mvel[CB-1];
      end
      OP_ADD: begin
        mb_r <= EW'(sel_mpos) + dsh;
      end
      OP_HIT: begin
        axis_r <= ax_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_REPORT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_REPORT) begin
      out_axis_r <= axis_r;
      out_time_r <= time_r;
      out_sat_r  <= sat_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit_axis       = out_axis_r;
  assign out_hit_time       = out_time_r;
  assign out_time_saturated = out_sat_r;

endmodule

`default_nettype wire

[design/swept_box_collision_test.sv]
// ----------------------------------------------------------------------------
// swept_box_collision_test
// swept box against static box collision test, signed fixed point
// ----------------------------------------------------------------------------
// a load word (opcode 0) stores the moving box, its velocity and the time
// budget and gives no result; a test word (opcode 1) brings one static box
// and gives one result word with hit axis, hit time and saturation flag
// axes are tried y, x, z; each axis with non-zero speed runs the serial
// divider for an NW-bit quotient, NW = COORD_BITS + 3 + FRAC_BITS, at one
// quotient bit per cycle, then one shared multiply, add and compare per
// other axis; a load word is stored without leaving the idle state, and
// a new word is taken once the last one is done
// the result sits in an output register, so the next word is accepted while
// the result waits; a test finishing while the register is still full waits
// for out_ready before its result is written
// reset clears the stored box, velocity and budget to zero and restores
// epsilon and margin_cap; the config port is always ready
// ----------------------------------------------------------------------------
`default_nettype none

module swept_box_collision_test
  import sbct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic signed [COORD_BITS-1:0]  in_box_x,
  input  wire logic signed [COORD_BITS-1:0]  in_box_y,
  input  wire logic signed [COORD_BITS-1:0]  in_box_z,
  input  wire logic [SIZE_BITS-1:0]          in_box_width,
  input  wire logic [SIZE_BITS-1:0]          in_box_height,
  input  wire logic [SIZE_BITS-1:0]          in_box_depth,
  input  wire logic signed [COORD_BITS-1:0]  in_vel_x,
  input  wire logic signed [COORD_BITS-1:0]  in_vel_y,
  input  wire logic signed [COORD_BITS-1:0]  in_vel_z,
  input  wire logic [COORD_BITS-2:0]         in_time_budget,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [AXIS_BITS-1:0]               out_hit_axis,
  output logic signed [COORD_BITS-1:0]       out_hit_time,
  output logic                               out_time_saturated
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  sbct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .st        (st),
    .cmd       (cmd)
  );

  sbct_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .cfg_we             (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .box_x              (in_box_x),
    .box_y              (in_box_y),
    .box_z              (in_box_z),
    .box_width          (in_box_width),
    .box_height         (in_box_height),
    .box_depth          (in_box_depth),
    .vel_x              (in_vel_x),
    .vel_y              (in_vel_y),
    .vel_z              (in_vel_z),
    .time_budget        (in_time_budget),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_hit_axis       (out_hit_axis),
    .out_hit_time       (out_hit_time),
    .out_time_saturated (out_time_saturated)
  );

endmodule

`default_nettype wire

[dv/swept_box_collision_test_test.sv]
// ----------------------------------------------------------------------------
// swept_box_collision_test_test
// self-checking bench for the swept box collision test: an in-bench predictor
// tracks the loaded moving box and the tolerance registers, and a scoreboard
// checks every result word in order under random idling on both channels,
// one long output hold-off and several epsilon and margin_cap settings
// ----------------------------------------------------------------------------
`default_nettype none

module swept_box_collision_test_test;
  import sbct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 500;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam longint T_MAX = (longint'(1) <<< (CB - 1)) - 1;
  localparam longint T_MIN = -(longint'(1) <<< (CB - 1));

  typedef struct {
    logic                  opcode;
    logic signed [CB-1:0]  pos [3];
    logic [SIZE_BITS-1:0]  size [3];
    logic signed [CB-1:0]  vel [3];
    logic [CB-2:0]         budget;
  } box_word_t;

  typedef struct {
    logic [AXIS_BITS-1:0] axis;
    logic [CB-1:0]        hit_time;
    logic                 sat;
  } hit_word_t;

  class hit_scoreboard;
    longint mpos [3];
    longint msize [3];
    longint mvel [3];
    longint budget;
    longint eps;
    longint cap;
    hit_word_t pending_hits [$];
    int errors;
    int tests;
    int hits;
    int sats;
    int axis_order [3];

    function new();
      axis_order = '{1, 0, 2};
      for (int i = 0; i < 3; i++) begin
        mpos[i] = 0;
        msize[i] = 0;
        mvel[i] = 0;
      end
      budget = 0;
      eps = EPS_RESET;
      cap = CAP_RESET;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_EPSILON) begin
        eps = data[EPS_BITS-1:0];
      end else if (idx == REG_MARGIN_CAP) begin
        cap = data[CAP_BITS-1:0];
      end
    endfunction

    function void note(box_word_t w);
      longint sp [3];
      longint ss [3];
      longint tm, q, span, av, dt, gap, d, mb;
      int a;
      logic sat;
      logic ok;
      logic [AXIS_BITS-1:0] axis;
      hit_word_t e;
      if (w.opcode == OPC_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          mpos[i] = w.pos[i];
          msize[i] = longint'(w.size[i]);
          mvel[i] = w.vel[i];
        end
        budget = longint'(w.budget);
        return;
      end
      for (int i = 0; i < 3; i++) begin
        sp[i] = w.pos[i];
        ss[i] = longint'(w.size[i]);
      end
      tm = budget;
      sat = 1'b0;
      axis = HIT_NONE;
      for (int k = 0; k < 3; k++) begin
        a = axis_order[k];
        if (mvel[a] == 0) continue;
        span = ((sp[a] + ss[a] > mpos[a] + msize[a]) ? sp[a] + ss[a] : mpos[a] + msize[a])
               - ((sp[a] < mpos[a]) ? sp[a] : mpos[a]) - (ss[a] + msize[a]);
        av = (mvel[a] < 0) ? -mvel[a] : mvel[a];
        q = (span * (longint'(1) <<< FB)) / av;
        sat = 1'b0;
        if (q > T_MAX) begin
          q = T_MAX;
          sat = 1'b1;
        end
        if (q < T_MIN) begin
          q = T_MIN;
          sat = 1'b1;
        end
        tm = q;
        if (!(q < budget)) break;
        dt = (q > 0) ? q : 0;
        gap = (mvel[a] > 0) ? sp[a] - (mpos[a] + msize[a]) : mpos[a] - (sp[a] + ss[a]);
        ok = (2 * gap > -ss[a]) && (gap > -cap);
        for (int b = 0; b < 3; b++) begin
          if (b == a || !ok) continue;
          d = (mvel[b] * dt) / (longint'(1) <<< FB);
          mb = mpos[b] + d;
          if (!((((mb + msize[b]) > (sp[b] + ss[b])) ? mb + msize[b] : sp[b] + ss[b])
                - ((mb < sp[b]) ? mb : sp[b]) < msize[b] + ss[b] - eps))
            ok = 1'b0;
        end
        if (ok) begin
          axis = AXIS_BITS'(a + 1);
          break;
        end
      end
      e.axis = axis;
      e.hit_time = tm[CB-1:0];
      e.sat = sat;
      pending_hits.push_back(e);
      tests++;
      if (axis != HIT_NONE) hits++;
      if (sat) sats++;
    endfunction

    task check(hit_word_t r);
      hit_word_t e;
      if (pending_hits.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      e = pending_hits.pop_front();
      if (r.axis !== e.axis)
        report($sformatf("hit_axis %0d, expected %0d", r.axis, e.axis));
      if (r.hit_time !== e.hit_time)
        report($sformatf("hit_time %0d, expected %0d",
                         $signed(r.hit_time), $signed(e.hit_time)));
      if (r.sat !== e.sat)
        report($sformatf("time_saturated %0b, expected %0b", r.sat, e.sat));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = 1'b0;
  logic signed [CB-1:0] in_box_x = '0, in_box_y = '0, in_box_z = '0;
  logic [SIZE_BITS-1:0] in_box_width = '0, in_box_height = '0, in_box_depth = '0;
  logic signed [CB-1:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic [CB-2:0] in_time_budget = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [AXIS_BITS-1:0] out_hit_axis;
  logic signed [CB-1:0] out_hit_time;
  logic out_time_saturated;

  hit_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int words_sent = 0;
  int idle_cycles = 0;

  swept_box_collision_test DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_box_x(in_box_x), .in_box_y(in_box_y), .in_box_z(in_box_z),
    .in_box_width(in_box_width), .in_box_height(in_box_height),
    .in_box_depth(in_box_depth),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .in_time_budget(in_time_budget),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit_axis(out_hit_axis),
    .out_hit_time(out_hit_time), .out_time_saturated(out_time_saturated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side
  initial begin
    int stall;
    hit_word_t r;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      r.axis = out_hit_axis;
      r.hit_time = out_hit_time;
      r.sat = out_time_saturated;
      sb.check(r);
    end
  end

  task automatic send_word(box_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= w.opcode;
    in_box_x <= w.pos[0];
    in_box_y <= w.pos[1];
    in_box_z <= w.pos[2];
    in_box_width <= w.size[0];
    in_box_height <= w.size[1];
    in_box_depth <= w.size[2];
    in_vel_x <= w.vel[0];
    in_vel_y <= w.vel[1];
    in_vel_z <= w.vel[2];
    in_time_budget <= w.budget;
    do @(posedge clk); while (!in_ready);
    sb.note(w);
    words_sent++;
  endtask

  task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic box_word_t make_word(logic opc, longint x, longint y, longint z,
                                          longint w, longint h, longint d,
                                          longint vx, longint vy, longint vz,
                                          longint bud);
    box_word_t b;
    b.opcode = opc;
    b.pos = '{CB'(x), CB'(y), CB'(z)};
    b.size = '{SIZE_BITS'(w), SIZE_BITS'(h), SIZE_BITS'(d)};
    b.vel = '{CB'(vx), CB'(vy), CB'(vz)};
    b.budget = (CB-1)'(bud);
    return b;
  endfunction

  function automatic box_word_t noise_word();
    box_word_t b;
    b.opcode = 1'($urandom_range(0, 1));
    for (int i = 0; i < 3; i++) begin
      b.pos[i] = CB'($urandom);
      b.size[i] = SIZE_BITS'($urandom);
      b.vel[i] = CB'($urandom);
    end
    b.budget = (CB-1)'($urandom);
    return b;
  endfunction

  function automatic longint srand(int lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  box_word_t load_w;

  task automatic random_load();
    longint v [3];
    for (int i = 0; i < 3; i++) v[i] = ($urandom_range(0, 3) == 0) ? 0 : srand(512);
    load_w = make_word(OPC_LOAD, srand(2048), srand(2048), srand(2048),
                       $urandom_range(16, 1024), $urandom_range(16, 1024),
                       $urandom_range(16, 1024), v[0], v[1], v[2],
                       $urandom_range(0, 4096));
    send_word(load_w);
  endtask

  // static box placed near the swept path
  task automatic random_test();
    longint t;
    longint p [3];
    box_word_t w;
    t = $urandom_range(0, int'(load_w.budget) + 256);
    for (int i = 0; i < 3; i++)
      p[i] = longint'(load_w.pos[i]) + (longint'(load_w.vel[i]) * t) / 256 + srand(300);
    w = make_word(OPC_TEST, p[0], p[1], p[2], $urandom_range(0, 1024),
                  $urandom_range(0, 1024), $urandom_range(0, 1024), 0, 0, 0, 0);
    for (int i = 0; i < 3; i++) w.vel[i] = CB'($urandom);
    w.budget = (CB-1)'($urandom);
    send_word(w);
  endtask

  task automatic random_phase(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      no_idle = ((sent / 80) % 3 == 2);
      if ($urandom_range(0, 99) < 12) begin
        send_word(noise_word());
        sent++;
      end else begin
        random_load();
        sent++;
        repeat ($urandom_range(1, 6)) begin
          random_test();
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    send_word(make_word(OPC_TEST, 100, 100, 100, 256, 256, 256, 0, 0, 0, 0));
    send_word(make_word(OPC_LOAD, 0, 0, 0, 256, 256, 256, 0, 0, 0, T_MAX));
    send_word(make_word(OPC_TEST, 512, 0, 0, 256, 256, 256, 0, 0, 0, 0));
    send_word(make_word(OPC_LOAD, 0, 0, 0, 256, 256, 256, 256, 0, 0, 1024));
    send_word(make_word(OPC_TEST, 512, 0, 0, 256, 256, 256, 0, 0, 0, 0));
    send_word(make_word(OPC_TEST, 512, 0, 0, 256, 256, 0, 0, 0, 0, 0));
    send_word(make_word(OPC_LOAD, 0, 0, 0, 256, 256, 256, 0, 0, -384, 2048));
    send_word(make_word(OPC_TEST, 0, 0, -1024, 256, 256, 256, 0, 0, 0, 0));
    send_word(make_word(OPC_LOAD, 0, 0, 0, 256, 256, 256, 0, -256, 0, 2048));
    send_word(make_word(OPC_TEST, 0, -700, 0, 256, 256, 256, 0, 0, 0, 0));
    send_word(make_word(OPC_LOAD, 0, 0, 0, 256, 256, 256, 0, 1, 0, T_MAX));
    send_word(make_word(OPC_TEST, 0, T_MAX, 0, 65535, 65535, 65535, 0, 0, 0, 0));
    send_word(make_word(OPC_LOAD, 0, 0, 0, 65535, 65535, 65535, 1, 1, 1, T_MAX));
    send_word(make_word(OPC_TEST, 0, 0, 0, 65535, 65535, 65535, 0, 0, 0, 0));
    send_word(make_word(OPC_LOAD, T_MIN, T_MAX, T_MIN, 0, 65535, 0,
                        T_MIN, T_MAX, T_MIN, 0));
    send_word(make_word(OPC_TEST, T_MAX, T_MIN, T_MAX, 65535, 0, 65535, 0, 0, 0, 0));
    send_word(make_word(OPC_LOAD, 0, 0, 0, 512, 512, 512, 128, 64, -32, 65536));
    send_word(make_word(OPC_TEST, 300, 100, 0, 512, 512, 512, 0, 0, 0, 0));
    send_word(make_word(OPC_TEST, -600, -600, -600, 512, 512, 512, 0, 0, 0, 0));
    send_word(make_word(OPC_TEST, T_MIN, T_MIN, T_MIN, 0, 0, 0, 0, 0, 0, 0));
    settle();

    // random phases with several register settings
    hold_req = 1'b1;
    random_phase(480);
    settle();
    write_cfg(REG_EPSILON, 16'h0000);
    write_cfg(REG_MARGIN_CAP, 16'h0000);
    write_cfg(REG_UNUSED, 16'hffff);
    random_phase(480);
    settle();
    write_cfg(REG_EPSILON, 16'hffff);
    write_cfg(REG_MARGIN_CAP, 16'hffff);
    write_cfg(2'd2, 16'h1234);
    random_phase(480);
    settle();
    write_cfg(REG_EPSILON, 16'($urandom));
    write_cfg(REG_MARGIN_CAP, 16'($urandom));
    random_phase(480);
    settle();

    $display("sent %0d words, %0d tests checked, %0d hits, %0d saturated times",
             words_sent, sb.tests, sb.hits, sb.sats);
    $display("four register settings, one long output hold-off, %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
